### sv/mir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mir_pkg;

    localparam int unsigned XLEN    = 32;
    localparam int unsigned NREG    = 32;
    localparam int unsigned RIDX_W  = $clog2(NREG);
    localparam int unsigned MAX_REC = 4;

    localparam logic [XLEN-1:0] RESET_PC  = 32'hbfc0_0000;
    localparam logic [XLEN-1:0] VEC_BEV0  = 32'hbfc0_0180;
    localparam logic [XLEN-1:0] VEC_BEV1  = 32'h8000_0080;
    localparam logic [XLEN-1:0] MFC0_MARK = 32'h0020_0000;
    localparam logic [RIDX_W-1:0] REG_LINK   = 5'd31;
    localparam logic [RIDX_W-1:0] COP0_SR    = 5'd12;
    localparam logic [RIDX_W-1:0] COP0_MF    = 5'd0;
    localparam logic [RIDX_W-1:0] COP0_MT    = 5'd4;
    localparam int unsigned SR_BEV = 22;

    // Record kinds.
    localparam logic [1:0] K_REG   = 2'd0;
    localparam logic [1:0] K_HILO  = 2'd1;
    localparam logic [1:0] K_MEM   = 2'd2;
    localparam logic [1:0] K_FETCH = 2'd3;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_LL      = 6'h30;
    localparam logic [5:0] OP_SC      = 6'h38;

    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MOVZ    = 6'h0a;
    localparam logic [5:0] FN_MOVN    = 6'h0b;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_BREAK   = 6'h0d;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;
    localparam logic [5:0] FN_DADDU   = 6'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [RIDX_W-1:0] idx;
        logic              rd;
        logic [2:0]        bytes;
        logic [XLEN-1:0]   addr;
        logic [XLEN-1:0]   val;
    } t_rec;

    function automatic t_rec mk_rec(input logic [1:0] kind, input logic [RIDX_W-1:0] idx,
                                    input logic rd, input logic [2:0] bytes,
                                    input logic [XLEN-1:0] addr,
                                    input logic [XLEN-1:0] val);
        t_rec r;
        r.kind  = kind;
        r.idx   = idx;
        r.rd    = rd;
        r.bytes = bytes;
        r.addr  = addr;
        r.val   = val;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/mir_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, with sign and divide-by-zero fixup.
module mir_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_signed,
    input  wire logic [mir_pkg::XLEN-1:0]  i_a,
    input  wire logic [mir_pkg::XLEN-1:0]  i_b,
    output logic                           o_done,
    output logic [mir_pkg::XLEN-1:0]       o_quo,
    output logic [mir_pkg::XLEN-1:0]       o_rem
);

    localparam int unsigned W   = mir_pkg::XLEN;
    localparam int unsigned CNT = $clog2(W);

    logic           r_busy;
    logic           r_fin;
    logic [CNT-1:0] r_cnt;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_mb;
    logic [W-1:0]   r_a;
    logic           r_negq;
    logic           r_negr;
    logic           r_zero;

    logic [W:0]     n_trial;
    logic [W:0]     n_diff;
    logic [W-1:0]   n_ma;
    logic [W-1:0]   n_mb;

    always_comb begin
        n_trial = {r_rem[W-1:0], r_quo[W-1]};
        n_diff  = n_trial - {1'b0, r_mb};
        n_ma    = (i_signed && i_a[W-1]) ? (~i_a + 1'b1) : i_a;
        n_mb    = (i_signed && i_b[W-1]) ? (~i_b + 1'b1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= n_ma;
            r_mb   <= n_mb;
            r_a    <= i_a;
            r_negq <= i_signed && (i_a[W-1] ^ i_b[W-1]);
            r_negr <= i_signed && i_a[W-1];
            r_zero <= (i_b == '0);
        end else if (r_busy) begin
            if (!n_diff[W]) begin
                r_rem <= n_diff;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_fin;
    assign o_quo  = r_zero ? '1 : (r_negq ? (~r_quo + 1'b1) : r_quo);
    assign o_rem  = r_zero ? r_a : (r_negr ? (~r_rem[W-1:0] + 1'b1) : r_rem[W-1:0]);

endmodule

`default_nettype wire

### sv/mips1_instruction_reference_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Trace-checking model of a 32-bit integer core. Each input beat carries one retired
// instruction, the address it was fetched from and the load data returned for it.
// The block executes it against a register file, HI/LO and a status word and sends
// out the expected records, one per output beat, in the order register write, HI/LO
// writes, memory access, expected fetch addresses; the final one has last_record set.
// Both channels use valid/ready. One instruction is handled at a time: the input is
// ready only in the idle state. The register file sits in two synchronous memory
// copies (one per source operand) read at the input beat; the instruction is then
// executed in the execute state and its records go out from the emit state, one
// record per cycle while the receiver is ready; a multiply adds a state and a divide
// waits in its own state for the bit-serial divider. A skipped slot or an instruction
// with no record goes back to idle from the execute state. When the receiver stalls
// the current record holds and no new instruction is taken. Reset clears the control
// state and the per-register valid bits, so every register reads as zero until
// written; current address restarts at the boot vector. No clearing pass is needed.
module mips1_instruction_reference_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_fetch_address,
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_load_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_record_kind,
    output logic [4:0]       o_reg_index,
    output logic             o_mem_is_read,
    output logic [2:0]       o_access_bytes,
    output logic [31:0]      o_access_address,
    output logic [31:0]      o_record_value,
    output logic             o_last_record
);

    localparam int unsigned W  = mir_pkg::XLEN;
    localparam int unsigned RW = mir_pkg::RIDX_W;
    localparam int unsigned NR = mir_pkg::NREG;
    localparam int unsigned CW = $clog2(mir_pkg::MAX_REC + 1);
    localparam int unsigned IW = $clog2(mir_pkg::MAX_REC);

    // Register file: two copies so both sources are read in the same cycle.
    logic [W-1:0] r_rf_a [NR];
    logic [W-1:0] r_rf_b [NR];
    logic [NR-1:0] r_rf_vld;
    logic [W-1:0] r_a_q;
    logic [W-1:0] r_b_q;
    logic         r_a_ok;
    logic         r_b_ok;

    mir_pkg::t_state r_state, n_state;

    logic [W-1:0] r_pc, r_ins, r_ld;
    logic [W-1:0] r_hi, n_hi, r_lo, n_lo, r_sr, n_sr;
    logic [W-1:0] r_cur, n_cur, r_nxt, n_nxt, r_epc, n_epc;
    logic         r_skip, n_skip, r_dslot, n_dslot;
    mir_pkg::t_rec r_rec [mir_pkg::MAX_REC];
    mir_pkg::t_rec n_rec [mir_pkg::MAX_REC];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_opa, r_opb;
    logic           r_msgn, n_msgn;

    logic          rf_we;
    logic [RW-1:0] rf_wa;
    logic [W-1:0]  rf_wd;
    logic          div_start;
    logic          div_sgn;
    logic          div_done;
    logic [W-1:0]  div_quo, div_rem;

    logic          in_acc;
    logic [W-1:0]  a, b;

    assign in_acc = i_in_valid && o_in_ready;
    assign a = r_a_ok ? r_a_q : '0;
    assign b = r_b_ok ? r_b_q : '0;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_q <= r_rf_a[i_instruction[25:21]];
            r_b_q <= r_rf_b[i_instruction[20:16]];
        end
        if (rf_we) begin
            r_rf_a[rf_wa] <= rf_wd;
            r_rf_b[rf_wa] <= rf_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_a_ok   <= 1'b0;
            r_b_ok   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_ok <= r_rf_vld[i_instruction[25:21]];
                r_b_ok <= r_rf_vld[i_instruction[20:16]];
            end
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
        end
    end

    mir_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_signed (div_sgn),
        .i_a      (a),
        .i_b      (b),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem    (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mir_pkg::ST_IDLE;
            r_hi    <= '0;
            r_lo    <= '0;
            r_sr    <= '0;
            r_cur   <= mir_pkg::RESET_PC;
            r_nxt   <= '0;
            r_epc   <= '0;
            r_skip  <= 1'b0;
            r_dslot <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            r_sr    <= n_sr;
            r_cur   <= n_cur;
            r_nxt   <= n_nxt;
            r_epc   <= n_epc;
            r_skip  <= n_skip;
            r_dslot <= n_dslot;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pc  <= i_fetch_address;
            r_ins <= i_instruction;
            r_ld  <= i_load_value;
        end
        r_rec  <= n_rec;
        r_msgn <= n_msgn;
        if (r_state == mir_pkg::ST_EXEC) begin
            r_prod <= a * b;
            r_opa  <= a;
            r_opb  <= b;
        end
    end

    always_comb begin
        logic [5:0]    op, fn;
        logic [RW-1:0] rs, rt, rd, sa;
        logic [15:0]   imm;
        logic [W-1:0]  simm, ptr, v, pnext, epc, hi_fix;
        logic          branch, likely, ltaken, jump, exc, hasreg, mem, mrd, cond;
        logic [RW-1:0] ridx;
        logic [2:0]    mby;
        logic [W-1:0]  mval;
        logic [CW-1:0] k;

        op   = r_ins[31:26];
        rs   = r_ins[25:21];
        rt   = r_ins[20:16];
        rd   = r_ins[15:11];
        sa   = r_ins[10:6];
        fn   = r_ins[5:0];
        imm  = r_ins[15:0];
        simm = {{16{imm[15]}}, imm};
        ptr  = a + simm;
        v      = '0;
        pnext  = r_pc + 32'd4;
        epc    = r_cur + 32'd4;
        hi_fix = '0;
        branch = 1'b0;
        likely = 1'b0;
        ltaken = 1'b0;
        jump   = 1'b0;
        exc    = 1'b0;
        hasreg = 1'b0;
        ridx   = '0;
        mem    = 1'b0;
        mrd    = 1'b0;
        mby    = '0;
        mval   = '0;
        cond   = 1'b0;
        k      = '0;

        n_state   = r_state;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_sr      = r_sr;
        n_cur     = r_cur;
        n_nxt     = r_nxt;
        n_epc     = r_epc;
        n_skip    = r_skip;
        n_dslot   = r_dslot;
        n_rec     = r_rec;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_msgn    = r_msgn;
        rf_we     = 1'b0;
        rf_wa     = '0;
        rf_wd     = '0;
        div_start = 1'b0;
        div_sgn   = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            mir_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = mir_pkg::ST_EXEC;
                end
            end

            mir_pkg::ST_EXEC: begin
                if (r_nxt != epc) begin
                    epc = epc | 32'd2;
                end
                n_cur = r_pc;
                n_idx = '0;
                if (r_skip) begin
                    n_skip  = 1'b0;
                    n_nxt   = pnext;
                    n_state = mir_pkg::ST_IDLE;
                end else begin
                    unique case (op)
                        mir_pkg::OP_SPECIAL: begin
                            unique case (fn)
                                mir_pkg::FN_SLL: begin
                                    v = b << sa; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SRL: begin
                                    v = b >> sa; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SRA: begin
                                    v = W'($signed(b) >>> sa); hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SLLV: begin
                                    v = b << a[4:0]; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SRLV: begin
                                    v = b >> a[4:0]; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SRAV: begin
                                    v = W'($signed(b) >>> a[4:0]); hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_JR: begin
                                    pnext = a; jump = 1'b1;
                                    n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_REG, '0,
                                        1'b0, 3'd0, '0, '0);
                                    k = k + 1'b1;
                                end
                                mir_pkg::FN_JALR: begin
                                    v = r_pc + 32'd8; pnext = a; jump = 1'b1;
                                    hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_MOVZ: begin
                                    if (b == '0 && rd != '0) begin
                                        rf_we = 1'b1; rf_wa = rd; rf_wd = a;
                                    end
                                end
                                mir_pkg::FN_MOVN: begin
                                    if (b != '0 && rd != '0) begin
                                        rf_we = 1'b1; rf_wa = rd; rf_wd = a;
                                    end
                                end
                                mir_pkg::FN_SYSCALL, mir_pkg::FN_BREAK: begin
                                    exc = 1'b1;
                                end
                                mir_pkg::FN_MFHI: begin
                                    v = r_hi; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_MFLO: begin
                                    v = r_lo; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_MTHI, mir_pkg::FN_MTLO: begin
                                    n_rec[0] = mir_pkg::mk_rec(mir_pkg::K_REG, '0, 1'b0,
                                        3'd0, '0, a);
                                    n_rec[1] = mir_pkg::mk_rec(mir_pkg::K_HILO,
                                        RW'(fn == mir_pkg::FN_MTHI), 1'b0, 3'd0, '0, a);
                                    k = CW'(2);
                                    if (fn == mir_pkg::FN_MTHI) begin
                                        n_hi = a;
                                    end else begin
                                        n_lo = a;
                                    end
                                end
                                mir_pkg::FN_MULT, mir_pkg::FN_MULTU,
                                mir_pkg::FN_DIV, mir_pkg::FN_DIVU: begin
                                    // Values of the HI/LO records are patched in later.
                                    n_rec[0] = mir_pkg::mk_rec(mir_pkg::K_REG, '0, 1'b0,
                                        3'd0, '0, '0);
                                    n_rec[1] = mir_pkg::mk_rec(mir_pkg::K_HILO, RW'(0),
                                        1'b0, 3'd0, '0, '0);
                                    n_rec[2] = mir_pkg::mk_rec(mir_pkg::K_HILO, RW'(1),
                                        1'b0, 3'd0, '0, '0);
                                    k = CW'(3);
                                    n_msgn = (fn == mir_pkg::FN_MULT);
                                    if (fn == mir_pkg::FN_DIV || fn == mir_pkg::FN_DIVU) begin
                                        div_start = 1'b1;
                                        div_sgn   = (fn == mir_pkg::FN_DIV);
                                    end
                                end
                                mir_pkg::FN_ADD, mir_pkg::FN_ADDU, mir_pkg::FN_DADDU: begin
                                    v = a + b; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SUB, mir_pkg::FN_SUBU: begin
                                    v = a - b; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_AND: begin
                                    v = a & b; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_OR: begin
                                    v = a | b; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_XOR: begin
                                    v = a ^ b; hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_NOR: begin
                                    v = ~(a | b); hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SLT: begin
                                    v = W'($signed(a) < $signed(b)); hasreg = 1'b1; ridx = rd;
                                end
                                mir_pkg::FN_SLTU: begin
                                    v = W'(a < b); hasreg = 1'b1; ridx = rd;
                                end
                                default: begin
                                end
                            endcase
                        end
                        mir_pkg::OP_REGIMM: begin
                            if (!(rt[4] && rt[3:0] > 4'd3) && !(!rt[4] && rt > RW'(3))) begin
                                if (rt[4]) begin
                                    v = r_pc + 32'd8; hasreg = 1'b1;
                                    ridx = mir_pkg::REG_LINK;
                                end
                                cond = rt[0] ? !a[W-1] : a[W-1];
                                if (rt[1]) begin
                                    likely = 1'b1; ltaken = cond;
                                end else begin
                                    branch = cond;
                                end
                            end
                        end
                        mir_pkg::OP_JAL: begin
                            v = r_pc + 32'd8; hasreg = 1'b1; ridx = mir_pkg::REG_LINK;
                            pnext = {r_pc[31:28], r_ins[25:0], 2'b00}; jump = 1'b1;
                        end
                        mir_pkg::OP_J: begin
                            pnext = {r_pc[31:28], r_ins[25:0], 2'b00}; jump = 1'b1;
                        end
                        mir_pkg::OP_BEQ:  branch = (a == b);
                        mir_pkg::OP_BNE:  branch = (a != b);
                        mir_pkg::OP_BLEZ: branch = (a == '0) || a[W-1];
                        mir_pkg::OP_BGTZ: branch = (a != '0) && !a[W-1];
                        mir_pkg::OP_BEQL: begin
                            likely = 1'b1; ltaken = (a == b);
                        end
                        mir_pkg::OP_BNEL: begin
                            likely = 1'b1; ltaken = (a != b);
                        end
                        mir_pkg::OP_BLEZL: begin
                            likely = 1'b1; ltaken = (a == '0) || a[W-1];
                        end
                        mir_pkg::OP_BGTZL: begin
                            likely = 1'b1; ltaken = (a != '0) && !a[W-1];
                        end
                        mir_pkg::OP_ADDI, mir_pkg::OP_ADDIU: begin
                            v = a + simm; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_SLTI: begin
                            v = W'($signed(a) < $signed(simm)); hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_SLTIU: begin
                            v = W'(a < simm); hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_ANDI: begin
                            v = a & {16'd0, imm}; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_ORI: begin
                            v = a | {16'd0, imm}; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_XORI: begin
                            v = a ^ {16'd0, imm}; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_LUI: begin
                            v = {imm, 16'd0}; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_COP0: begin
                            if (rs == mir_pkg::COP0_MF) begin
                                v = (rd == mir_pkg::COP0_SR) ? (r_sr | mir_pkg::MFC0_MARK) : b;
                                hasreg = 1'b1; ridx = rt;
                            end else if (rs == mir_pkg::COP0_MT && rd == mir_pkg::COP0_SR) begin
                                n_sr = b;
                            end
                        end
                        mir_pkg::OP_LB: begin
                            v = {{24{r_ld[7]}}, r_ld[7:0]}; mby = 3'd1;
                            hasreg = 1'b1; ridx = rt; mem = 1'b1; mrd = 1'b1;
                        end
                        mir_pkg::OP_LH: begin
                            v = {{16{r_ld[15]}}, r_ld[15:0]}; mby = 3'd2;
                            hasreg = 1'b1; ridx = rt; mem = 1'b1; mrd = 1'b1;
                        end
                        mir_pkg::OP_LWL, mir_pkg::OP_LW: begin
                            v = r_ld; mby = 3'd4;
                            hasreg = 1'b1; ridx = rt; mem = 1'b1; mrd = 1'b1;
                        end
                        mir_pkg::OP_LBU: begin
                            v = {24'd0, r_ld[7:0]}; mby = 3'd1;
                            hasreg = 1'b1; ridx = rt; mem = 1'b1; mrd = 1'b1;
                        end
                        mir_pkg::OP_LHU: begin
                            v = {16'd0, r_ld[15:0]}; mby = 3'd2;
                            hasreg = 1'b1; ridx = rt; mem = 1'b1; mrd = 1'b1;
                        end
                        mir_pkg::OP_LL: begin
                            v = r_ld; hasreg = 1'b1; ridx = rt;
                        end
                        mir_pkg::OP_SB: begin
                            mem = 1'b1; mby = 3'd1; mval = b;
                        end
                        mir_pkg::OP_SH: begin
                            mem = 1'b1; mby = 3'd2; mval = b;
                        end
                        mir_pkg::OP_SWL, mir_pkg::OP_SW, mir_pkg::OP_SC: begin
                            mem = 1'b1; mby = 3'd4; mval = b;
                        end
                        default: begin
                        end
                    endcase

                    if (hasreg) begin
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_REG, ridx, 1'b0,
                            3'd0, '0, v);
                        k = k + 1'b1;
                        if (ridx != '0) begin
                            rf_we = 1'b1; rf_wa = ridx; rf_wd = v;
                        end
                    end
                    if (mem) begin
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_MEM, '0, mrd, mby,
                            ptr, mval);
                        k = k + 1'b1;
                    end

                    if (branch || ltaken) begin
                        pnext = pnext + {simm[W-3:0], 2'b00};
                    end
                    pnext  = {pnext[W-1:2], 2'b00};
                    n_skip = likely && !ltaken;

                    if (exc) begin
                        pnext   = r_sr[mir_pkg::SR_BEV] ? mir_pkg::VEC_BEV1 : mir_pkg::VEC_BEV0;
                        n_epc   = epc | 32'd1;
                        n_skip  = 1'b1;
                        n_dslot = 1'b0;
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_FETCH, '0, 1'b0,
                            3'd0, '0, pnext);
                        k = k + 1'b1;
                    end else if (r_dslot) begin
                        n_dslot = 1'b0;
                    end else if (branch || ltaken || jump) begin
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_FETCH, '0, 1'b0,
                            3'd0, '0, r_pc + 32'd4);
                        k = k + 1'b1;
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_FETCH, '0, 1'b0,
                            3'd0, '0, pnext);
                        k = k + 1'b1;
                        n_dslot = 1'b1;
                    end else begin
                        n_rec[k[IW-1:0]] = mir_pkg::mk_rec(mir_pkg::K_FETCH, '0, 1'b0,
                            3'd0, '0, pnext);
                        k = k + 1'b1;
                    end
                    n_nxt = pnext;
                    n_cnt = k;

                    if (op == mir_pkg::OP_SPECIAL &&
                        (fn == mir_pkg::FN_MULT || fn == mir_pkg::FN_MULTU)) begin
                        n_state = mir_pkg::ST_MUL;
                    end else if (op == mir_pkg::OP_SPECIAL &&
                        (fn == mir_pkg::FN_DIV || fn == mir_pkg::FN_DIVU)) begin
                        n_state = mir_pkg::ST_DIV;
                    end else if (k == '0) begin
                        n_state = mir_pkg::ST_IDLE;
                    end else begin
                        n_state = mir_pkg::ST_EMIT;
                    end
                end
            end

            mir_pkg::ST_MUL: begin
                // Signed product from the unsigned one: subtract the cross terms from HI.
                hi_fix = r_prod[2*W-1:W];
                if (r_msgn && r_opa[W-1]) begin
                    hi_fix = hi_fix - r_opb;
                end
                if (r_msgn && r_opb[W-1]) begin
                    hi_fix = hi_fix - r_opa;
                end
                n_lo = r_prod[W-1:0];
                n_hi = hi_fix;
                n_rec[1].val = r_prod[W-1:0];
                n_rec[2].val = hi_fix;
                n_state = mir_pkg::ST_EMIT;
            end

            mir_pkg::ST_DIV: begin
                if (div_done) begin
                    n_lo = div_quo;
                    n_hi = div_rem;
                    n_rec[1].val = div_quo;
                    n_rec[2].val = div_rem;
                    n_state = mir_pkg::ST_EMIT;
                end
            end

            mir_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if ({1'b0, r_idx} == r_cnt - 1'b1) begin
                        n_state = mir_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            default: begin
                n_state = mir_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_record_kind    = r_rec[r_idx].kind;
    assign o_reg_index      = r_rec[r_idx].idx;
    assign o_mem_is_read    = r_rec[r_idx].rd;
    assign o_access_bytes   = r_rec[r_idx].bytes;
    assign o_access_address = r_rec[r_idx].addr;
    assign o_record_value   = r_rec[r_idx].val;
    assign o_last_record    = ({1'b0, r_idx} == r_cnt - 1'b1);

endmodule

`default_nettype wire

### sv/mir_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mir_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_record_kind,
    input wire logic [4:0]  o_reg_index,
    input wire logic [2:0]  o_access_bytes,
    input wire logic [31:0] o_record_value,
    input wire logic        o_last_record
);

    // A pending record must hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_record_value))
        else $error("record dropped or changed while stalled");

    // One instruction at a time: no new beat while records are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while records pending");

    // Only memory records carry a size.
    a_bytes_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind != mir_pkg::K_MEM |-> o_access_bytes == 3'd0)
        else $error("access size on a non-memory record");

    // A fetch record is never followed by a non-fetch record of the same instruction.
    a_fetch_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_record_kind == mir_pkg::K_FETCH && !o_last_record
        |=> o_out_valid && o_record_kind == mir_pkg::K_FETCH)
        else $error("record out of order after fetch record");

    // After a final record the block returns to accepting input.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_record |=> !o_out_valid && o_in_ready)
        else $error("block did not return to idle");

endmodule

bind mips1_instruction_reference_step mir_chk u_mir_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_record_kind  (o_record_kind),
    .o_reg_index    (o_reg_index),
    .o_access_bytes (o_access_bytes),
    .o_record_value (o_record_value),
    .o_last_record  (o_last_record)
);

`default_nettype wire

### bench/tb_mips1_instruction_reference_step.sv
`timescale 1ns / 1ps

// One expected trace record, at the widths of the output ports.
typedef struct {
    logic [1:0]  kind;
    logic [4:0]  idx;
    logic        rd;
    logic [2:0]  bytes;
    logic [31:0] addr;
    logic [31:0] val;
    logic        last;
} trace_rec_t;

// Scoreboard: keeps its own copy of the architectural state, works out the records
// that each accepted instruction should produce and checks the output beats
// against them in order.
class trace_scoreboard;
    logic [31:0] gpr[32];
    logic [31:0] hi_q, lo_q, status_q, cur_pc, next_pc, epc_q;
    bit          skip_q, slot_q;
    trace_rec_t  pending[$];
    int          errors;
    int          records_seen;

    function void clear();
        foreach (gpr[i]) gpr[i] = '0;
        hi_q = '0; lo_q = '0; status_q = '0;
        cur_pc = mir_pkg::RESET_PC; next_pc = '0; epc_q = '0;
        skip_q = 0; slot_q = 0;
        pending.delete();
        errors = 0;
        records_seen = 0;
    endfunction

    function void push(logic [1:0] k, logic [4:0] i, logic r, logic [2:0] b,
                       logic [31:0] ad, logic [31:0] v);
        trace_rec_t t;
        t.kind = k; t.idx = i; t.rd = r; t.bytes = b; t.addr = ad; t.val = v; t.last = 0;
        pending.push_back(t);
    endfunction

    function void wr(logic [4:0] i, logic [31:0] v);
        if (i != 0) gpr[i] = v;
    endfunction

    // Register write with its record, the most common result.
    function void wrec(logic [4:0] i, logic [31:0] v);
        wr(i, v);
        push(mir_pkg::K_REG, i, 0, 0, 0, v);
    endfunction

    function void note_instruction(logic [31:0] pc, logic [31:0] ins, logic [31:0] ld);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic [31:0] imm, simm, a, b, v, epc, pnext, q, r, ma, mb;
        logic [63:0] prod;
        bit          br, likely, ltaken, jump, exc, mem, m_rd, hl;
        logic [2:0]  m_by;
        logic [31:0] m_val;
        int          base;
        op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
        rd = ins[15:11]; sa = ins[10:6]; fn = ins[5:0];
        imm = {16'h0, ins[15:0]}; simm = {{16{ins[15]}}, ins[15:0]};
        a = gpr[rs]; b = gpr[rt];
        br = 0; likely = 0; ltaken = 0; jump = 0; exc = 0; mem = 0; m_rd = 0; hl = 0;
        m_by = 0; m_val = 0;
        base = pending.size();
        epc = cur_pc + 4;
        if (next_pc != cur_pc + 4) epc[1] = 1'b1;
        cur_pc = pc;
        pnext = pc + 4;
        // The slot of a branch-likely that was not taken, or the beat after a trap, is dropped without trace.
        if (skip_q) begin
            skip_q = 0;
            next_pc = pnext;
            return;
        end
        case (op)
            mir_pkg::OP_SPECIAL: begin
                case (fn)
                    mir_pkg::FN_SLL:  wrec(rd, b << sa);
                    mir_pkg::FN_SRL:  wrec(rd, b >> sa);
                    mir_pkg::FN_SRA:  wrec(rd, $signed(b) >>> sa);
                    mir_pkg::FN_SLLV: wrec(rd, b << a[4:0]);
                    mir_pkg::FN_SRLV: wrec(rd, b >> a[4:0]);
                    mir_pkg::FN_SRAV: wrec(rd, $signed(b) >>> a[4:0]);
                    mir_pkg::FN_JR: begin
                        pnext = a; jump = 1; push(mir_pkg::K_REG, 0, 0, 0, 0, 0);
                    end
                    mir_pkg::FN_JALR: begin
                        pnext = a; jump = 1; wrec(rd, pc + 8);
                    end
                    mir_pkg::FN_MOVZ: if (b == 0) wr(rd, a);
                    mir_pkg::FN_MOVN: if (b != 0) wr(rd, a);
                    mir_pkg::FN_SYSCALL, mir_pkg::FN_BREAK: exc = 1;
                    mir_pkg::FN_MFHI: wrec(rd, hi_q);
                    mir_pkg::FN_MFLO: wrec(rd, lo_q);
                    mir_pkg::FN_MTHI: begin
                        hi_q = a;
                        push(mir_pkg::K_REG, 0, 0, 0, 0, a);
                        push(mir_pkg::K_HILO, 1, 0, 0, 0, a);
                    end
                    mir_pkg::FN_MTLO: begin
                        lo_q = a;
                        push(mir_pkg::K_REG, 0, 0, 0, 0, a);
                        push(mir_pkg::K_HILO, 0, 0, 0, 0, a);
                    end
                    mir_pkg::FN_MULT, mir_pkg::FN_MULTU: begin
                        if (fn == mir_pkg::FN_MULT)
                            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        else
                            prod = {32'h0, a} * {32'h0, b};
                        lo_q = prod[31:0]; hi_q = prod[63:32]; hl = 1;
                    end
                    mir_pkg::FN_DIV, mir_pkg::FN_DIVU: begin
                        // Divide by zero: quotient all-ones, remainder the dividend.
                        if (b == 0) begin
                            lo_q = '1; hi_q = a;
                        end else if (fn == mir_pkg::FN_DIVU) begin
                            lo_q = a / b; hi_q = a % b;
                        end else begin
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            q = ma / mb; r = ma % mb;
                            if (a[31] ^ b[31]) q = -q;
                            if (a[31]) r = -r;
                            lo_q = q; hi_q = r;
                        end
                        hl = 1;
                    end
                    mir_pkg::FN_ADD, mir_pkg::FN_ADDU, mir_pkg::FN_DADDU: wrec(rd, a + b);
                    mir_pkg::FN_SUB, mir_pkg::FN_SUBU: wrec(rd, a - b);
                    mir_pkg::FN_AND: wrec(rd, a & b);
                    mir_pkg::FN_OR:  wrec(rd, a | b);
                    mir_pkg::FN_XOR: wrec(rd, a ^ b);
                    mir_pkg::FN_NOR: wrec(rd, ~(a | b));
                    mir_pkg::FN_SLT: wrec(rd, ($signed(a) < $signed(b)) ? 1 : 0);
                    mir_pkg::FN_SLTU: wrec(rd, (a < b) ? 1 : 0);
                    default: ;
                endcase
                if (hl) begin
                    push(mir_pkg::K_REG, 0, 0, 0, 0, 0);
                    push(mir_pkg::K_HILO, 0, 0, 0, 0, lo_q);
                    push(mir_pkg::K_HILO, 1, 0, 0, 0, hi_q);
                end
            end
            mir_pkg::OP_REGIMM: begin
                // Link forms write r31 even when the branch is not taken.
                if (!(rt[4] && rt > 5'h13) && !(!rt[4] && rt > 5'h03)) begin
                    if (rt[4]) wrec(mir_pkg::REG_LINK, pc + 8);
                    v = rt[0] ? {31'h0, !a[31]} : {31'h0, a[31]};
                    if (rt[1]) begin
                        likely = 1; ltaken = v[0];
                    end else br = v[0];
                end
            end
            mir_pkg::OP_JAL: begin
                wrec(mir_pkg::REG_LINK, pc + 8);
                pnext = {pc[31:28], ins[25:0], 2'b00}; jump = 1;
            end
            mir_pkg::OP_J: begin
                pnext = {pc[31:28], ins[25:0], 2'b00}; jump = 1;
            end
            mir_pkg::OP_BEQ:   br = (a == b);
            mir_pkg::OP_BNE:   br = (a != b);
            mir_pkg::OP_BLEZ:  br = (a == 0) || a[31];
            mir_pkg::OP_BGTZ:  br = (a != 0) && !a[31];
            mir_pkg::OP_BEQL:  begin likely = 1; ltaken = (a == b); end
            mir_pkg::OP_BNEL:  begin likely = 1; ltaken = (a != b); end
            mir_pkg::OP_BLEZL: begin likely = 1; ltaken = (a == 0) || a[31]; end
            mir_pkg::OP_BGTZL: begin likely = 1; ltaken = (a != 0) && !a[31]; end
            mir_pkg::OP_ADDI, mir_pkg::OP_ADDIU: wrec(rt, a + simm);
            mir_pkg::OP_SLTI:  wrec(rt, ($signed(a) < $signed(simm)) ? 1 : 0);
            mir_pkg::OP_SLTIU: wrec(rt, (a < simm) ? 1 : 0);
            mir_pkg::OP_ANDI:  wrec(rt, a & imm);
            mir_pkg::OP_ORI:   wrec(rt, a | imm);
            mir_pkg::OP_XORI:  wrec(rt, a ^ imm);
            mir_pkg::OP_LUI:   wrec(rt, imm << 16);
            mir_pkg::OP_COP0: begin
                if (rs == mir_pkg::COP0_MF)
                    wrec(rt, (rd == mir_pkg::COP0_SR) ? (status_q | mir_pkg::MFC0_MARK) : b);
                else if (rs == mir_pkg::COP0_MT && rd == mir_pkg::COP0_SR)
                    status_q = b;
            end
            mir_pkg::OP_LB:  begin wrec(rt, {{24{ld[7]}}, ld[7:0]}); mem = 1; m_rd = 1; m_by = 1; end
            mir_pkg::OP_LH:  begin wrec(rt, {{16{ld[15]}}, ld[15:0]}); mem = 1; m_rd = 1; m_by = 2; end
            mir_pkg::OP_LWL, mir_pkg::OP_LW: begin wrec(rt, ld); mem = 1; m_rd = 1; m_by = 4; end
            mir_pkg::OP_LBU: begin wrec(rt, {24'h0, ld[7:0]}); mem = 1; m_rd = 1; m_by = 1; end
            mir_pkg::OP_LHU: begin wrec(rt, {16'h0, ld[15:0]}); mem = 1; m_rd = 1; m_by = 2; end
            mir_pkg::OP_LL:  wrec(rt, ld);
            mir_pkg::OP_SB:  begin mem = 1; m_by = 1; m_val = b; end
            mir_pkg::OP_SH:  begin mem = 1; m_by = 2; m_val = b; end
            mir_pkg::OP_SWL, mir_pkg::OP_SW, mir_pkg::OP_SC: begin
                mem = 1; m_by = 4; m_val = b;
            end
            default: ;
        endcase
        if (mem) push(mir_pkg::K_MEM, 0, m_rd, m_by, a + simm, m_val);
        if (br || ltaken) pnext = pnext + (simm << 2);
        pnext[1:0] = 2'b00;
        skip_q = likely && !ltaken;
        if (exc) begin
            pnext = status_q[mir_pkg::SR_BEV] ? mir_pkg::VEC_BEV1 : mir_pkg::VEC_BEV0;
            epc_q = epc | 32'h1;
            skip_q = 1;
            slot_q = 0;
            push(mir_pkg::K_FETCH, 0, 0, 0, 0, pnext);
        end else if (slot_q) begin
            // The delay slot itself brings no fetch record.
            slot_q = 0;
        end else if (br || ltaken || jump) begin
            push(mir_pkg::K_FETCH, 0, 0, 0, 0, pc + 4);
            push(mir_pkg::K_FETCH, 0, 0, 0, 0, pnext);
            slot_q = 1;
        end else begin
            push(mir_pkg::K_FETCH, 0, 0, 0, 0, pnext);
        end
        next_pc = pnext;
        if (pending.size() > base) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_record(trace_rec_t got);
        trace_rec_t want;
        records_seen++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected record kind=%0d value=%h", $time, got.kind, got.val);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.kind !== want.kind) begin
            $display("%0t: record_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.idx !== want.idx) begin
            $display("%0t: reg_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
        end
        if (got.rd !== want.rd) begin
            $display("%0t: mem_is_read expected %0d actual %0d", $time, want.rd, got.rd);
            errors++;
        end
        if (got.bytes !== want.bytes) begin
            $display("%0t: access_bytes expected %0d actual %0d", $time, want.bytes, got.bytes);
            errors++;
        end
        if (got.addr !== want.addr) begin
            $display("%0t: access_address expected %h actual %h", $time, want.addr, got.addr);
            errors++;
        end
        if (got.val !== want.val) begin
            $display("%0t: record_value expected %h actual %h", $time, want.val, got.val);
            errors++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last_record expected %0d actual %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_mips1_instruction_reference_step;
    import mir_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_fetch_address;
    logic [31:0] i_instruction;
    logic [31:0] i_load_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_record_kind;
    logic [4:0]  o_reg_index;
    logic        o_mem_is_read;
    logic [2:0]  o_access_bytes;
    logic [31:0] o_access_address;
    logic [31:0] o_record_value;
    logic        o_last_record;

    trace_scoreboard sb;
    logic [31:0] pc_model;     // Sequential address for the next instruction beat.
    int          beats_sent;
    int          idle_cycles;
    bit          stim_done;
    bit          hold_off;     // Set while the receiver deliberately stalls for long.

    mips1_instruction_reference_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_fetch_address  (i_fetch_address),
        .i_instruction    (i_instruction),
        .i_load_value     (i_load_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_kind    (o_record_kind),
        .o_reg_index      (o_reg_index),
        .o_mem_is_read    (o_mem_is_read),
        .o_access_bytes   (o_access_bytes),
        .o_access_address (o_access_address),
        .o_record_value   (o_record_value),
        .o_last_record    (o_last_record)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one instruction beat, waits for its acceptance and hands it to the
    // scoreboard at the edge where it is taken. Valid drops only when a gap follows,
    // so back-to-back beats keep it high.
    task automatic send_beat(input logic [31:0] pc, input logic [31:0] ins,
                             input logic [31:0] ld);
        int gap;
        gap = gap_cycles();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_fetch_address <= pc;
        i_instruction   <= ins;
        i_load_value    <= ld;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_instruction(pc, ins, ld);
        beats_sent++;
        pc_model = pc + 4;
    endtask

    function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sa, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Random operation, weighted toward the ones that touch registers and memory.
    function automatic logic [31:0] random_instruction();
        logic [5:0] ops[] = '{OP_ADDIU, OP_ORI, OP_LUI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_XORI,
                              OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWL, OP_LL,
                              OP_SB, OP_SH, OP_SW, OP_SWL, OP_SC, OP_BEQ, OP_BNE, OP_BLEZ,
                              OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL, OP_REGIMM,
                              OP_J, OP_JAL, OP_COP0};
        logic [5:0] fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                              FN_JALR, FN_MOVZ, FN_MOVN, FN_SYSCALL, FN_BREAK, FN_MFHI,
                              FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
                              FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                              FN_NOR, FN_SLT, FN_SLTU, FN_DADDU};
        logic [31:0] w;
        int pick;
        w = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 45)
            w[5:0] = fns[$urandom_range(0, fns.size() - 1)];
        if (pick < 45)
            w[31:26] = OP_SPECIAL;
        else if (pick < 93)
            w[31:26] = ops[$urandom_range(0, ops.size() - 1)];
        // The rest keep fully random words, so unassigned codes show up too.
        if (w[31:26] == OP_COP0 && $urandom_range(0, 1)) begin
            w[25:21] = $urandom_range(0, 1) ? COP0_MF : COP0_MT;
            w[15:11] = COP0_SR;
        end
        return w;
    endfunction

    // Output side: random stalls, plus one long deliberate hold-off.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        hold_off    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                trace_rec_t got;
                got.kind  = o_record_kind;
                got.idx   = o_reg_index;
                got.rd    = o_mem_is_read;
                got.bytes = o_access_bytes;
                got.addr  = o_access_address;
                got.val   = o_record_value;
                got.last  = o_last_record;
                sb.check_record(got);
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else begin
                gap = gap_cycles();
                i_out_ready <= (gap == 0) || ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int k;
        logic [31:0] ins;
        sb = new();
        sb.clear();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_fetch_address = '0;
        i_instruction   = '0;
        i_load_value    = '0;
        beats_sent      = 0;
        stim_done       = 0;
        pc_model        = RESET_PC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: operand extremes, the multiply/divide corner cases,
        // branch-likely skipping, delay slots and both exception vectors.
        send_beat(pc_model, i_type(OP_LUI, 0, 1, 16'h8000), '0);
        send_beat(pc_model, i_type(OP_ADDIU, 0, 2, 16'hffff), '0);
        send_beat(pc_model, r_type(1, 2, 3, 0, FN_MULT), '0);       // signed 64-bit product
        send_beat(pc_model, r_type(1, 2, 4, 0, FN_DIV), '0);        // min over minus one
        send_beat(pc_model, r_type(2, 0, 5, 0, FN_DIVU), '0);       // divide by zero
        send_beat(pc_model, r_type(2, 1, 6, 0, FN_SRAV), '0);       // shift uses five bits
        send_beat(pc_model, r_type(0, 2, 0, 31, FN_SLL), '0);       // write to register zero
        send_beat(pc_model, i_type(OP_LB, 1, 7, 16'h8000), 32'hffff_ff80);
        send_beat(pc_model, i_type(OP_LHU, 2, 8, 16'h7fff), 32'hffff_ffff);
        send_beat(pc_model, i_type(OP_LL, 0, 9, 16'h0), 32'h1234_5678);
        send_beat(pc_model, i_type(OP_SC, 2, 9, 16'h0004), '0);
        send_beat(pc_model, r_type(2, 0, 10, 0, FN_MOVZ), '0);
        send_beat(pc_model, i_type(OP_BEQL, 1, 0, 16'h0010), '0);   // not taken: slot skipped
        send_beat(pc_model, i_type(OP_ADDIU, 0, 11, 16'h0001), '0);
        send_beat(pc_model, i_type(OP_BEQ, 0, 0, 16'h0004), '0);    // taken, then its slot
        send_beat(pc_model, i_type(OP_ORI, 0, 12, 16'hffff), '0);
        send_beat(pc_model, r_type(0, 0, 0, 0, FN_SYSCALL), '0);    // BEV clear
        send_beat(pc_model, '0, '0);                                // skipped after trap
        send_beat(pc_model, i_type(OP_LUI, 0, 13, 16'h0040), '0);
        send_beat(pc_model, {OP_COP0, COP0_MT, 5'd13, COP0_SR, 11'h0}, '0);
        send_beat(pc_model, {OP_COP0, COP0_MF, 5'd14, COP0_SR, 11'h0}, '0);
        send_beat(pc_model, r_type(0, 0, 0, 0, FN_BREAK), '0);      // BEV set
        send_beat(pc_model, '0, '0);
        send_beat(pc_model, 32'hffff_ffff, 32'hffff_ffff);          // unassigned opcode

        // Random part. Addresses mostly follow the sequential flow with random
        // instruction content; now and then a random address breaks the flow.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            ins = random_instruction();
            if (k == RANDOM_ITEMS / 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (150) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            send_beat(($urandom_range(0, 9) == 0) ? $urandom() : pc_model, ins, $urandom());
        end
        i_in_valid <= 1'b0;
        stim_done = 1;

        k = 0;
        while (sb.pending.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d instruction beats and %0d checked records.",
                 beats_sent, sb.records_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d records still outstanding",
                     sb.errors, sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
